>>> rtl/mcr_pkg.sv
// shared constants and types for the midpoint circle rasterizer
package mcr_pkg;

    localparam int COORD_BITS_DEF  = 15;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int RADIUS_W = 14;
    localparam int ORIGIN_W = 14;
    localparam int PIXEL_W  = 17;
    localparam int ARC_W    = 15;   // arc point, signed, one bit above the radius
    localparam int DEC_W    = 32;   // midpoint test value, scaled by four
    localparam int REFL_W   = 3;    // eight reflections per step

    localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = ORIGIN_W'(300);

    localparam logic [REFL_W-1:0] REFL_LAST = {REFL_W{1'b1}};

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef enum logic {
        CFG_ORIGIN_X = 1'b0,
        CFG_ORIGIN_Y = 1'b1
    } cfg_idx_t;

    // front to back handshake with the job queue
    typedef struct packed {
        logic push;
        logic full;
    } queue_wr_t;

endpackage

>>> rtl/mcr_queue.sv
// short job queue between the command front end and the pixel back end
module mcr_queue #(
    parameter int WIDTH = 61,
    parameter int DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/mcr_front.sv
// command front end: holds the circle, walks the arc point, queues one job per step
module mcr_front #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_accept,
    input  mcr_pkg::cmd_t                      in_cmd,
    input  logic signed [COORD_BITS-1:0]       in_cen_x,
    input  logic signed [COORD_BITS-1:0]       in_cen_y,
    input  logic [mcr_pkg::RADIUS_W-1:0]       in_radius,
    input  logic                               queue_full,
    output mcr_pkg::queue_wr_t                 queue_wr,
    output logic signed [COORD_BITS-1:0]       job_cen_x,
    output logic signed [COORD_BITS-1:0]       job_cen_y,
    output logic signed [mcr_pkg::ARC_W-1:0]   job_arc_x,
    output logic signed [mcr_pkg::ARC_W-1:0]   job_arc_y,
    output logic                               job_done
);

    localparam int ARC_W = mcr_pkg::ARC_W;
    localparam int DEC_W = mcr_pkg::DEC_W;

    logic signed [COORD_BITS-1:0] cen_x_reg, cen_y_reg;
    logic signed [ARC_W-1:0]      arc_x_reg, arc_x_next;
    logic signed [ARC_W-1:0]      arc_y_reg, arc_y_next;
    logic signed [DEC_W-1:0]      dec_reg, dec_next, dec_init;
    logic signed [DEC_W-1:0]      ax_ext, ay_ext, step_x, step_y;
    logic                         active_reg;
    logic                         outside;
    logic                         done;
    logic                         do_start, do_step;

    assign do_start = in_accept && (in_cmd == mcr_pkg::CMD_START);
    assign do_step  = in_accept && (in_cmd == mcr_pkg::CMD_STEP) && active_reg;

    // test value at (0, r) is 5 - 4r
    assign dec_init = DEC_W'(5) - ({{(DEC_W - mcr_pkg::RADIUS_W){1'b0}}, in_radius} << 2);

    assign ax_ext = DEC_W'(arc_x_reg);
    assign ay_ext = DEC_W'(arc_y_reg);
    assign step_x = (ax_ext <<< 3) + DEC_W'(12);   // x to x+1 moves D by 8x+12
    assign step_y = DEC_W'(8) - (ay_ext <<< 3);    // y to y-1 moves D by 8-8y

    assign outside    = !dec_reg[DEC_W-1];
    assign arc_y_next = outside ? arc_y_reg - 1'b1 : arc_y_reg;
    assign arc_x_next = arc_x_reg + 1'b1;
    assign done       = (arc_x_next > arc_y_next);
    assign dec_next   = outside ? dec_reg + step_x + step_y : dec_reg + step_x;

    assign queue_wr.push = do_step;
    assign queue_wr.full = queue_full;
    assign job_cen_x     = cen_x_reg;
    assign job_cen_y     = cen_y_reg;
    assign job_arc_x     = arc_x_reg;
    assign job_arc_y     = arc_y_reg;
    assign job_done      = done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (do_start) begin
            active_reg <= 1'b1;
        end else if (do_step && done) begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_start) begin
            cen_x_reg <= in_cen_x;
            cen_y_reg <= in_cen_y;
            arc_x_reg <= '0;
            arc_y_reg <= ARC_W'(in_radius);
            dec_reg   <= dec_init;
        end else if (do_step) begin
            arc_x_reg <= arc_x_next;
            arc_y_reg <= arc_y_next;
            dec_reg   <= dec_next;
        end
    end

endmodule

>>> rtl/mcr_back.sv
// pixel back end: expands each queued arc point into eight reflected pixels
module mcr_back #(
    parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  mcr_pkg::cfg_idx_t                  cfg_index,
    input  logic [mcr_pkg::ORIGIN_W-1:0]       cfg_wdata,
    input  logic                               job_valid,
    input  logic signed [COORD_BITS-1:0]       job_cen_x,
    input  logic signed [COORD_BITS-1:0]       job_cen_y,
    input  logic signed [mcr_pkg::ARC_W-1:0]   job_arc_x,
    input  logic signed [mcr_pkg::ARC_W-1:0]   job_arc_y,
    input  logic                               job_done,
    output logic                               job_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mcr_pkg::PIXEL_W-1:0] out_pixel_x,
    output logic signed [mcr_pkg::PIXEL_W-1:0] out_pixel_y,
    output logic                               out_last,
    output logic                               out_done
);

    localparam int ARC_W   = mcr_pkg::ARC_W;
    localparam int PIXEL_W = mcr_pkg::PIXEL_W;
    localparam int REFL_W  = mcr_pkg::REFL_W;
    localparam int SUM_W   = ((COORD_BITS > ARC_W) ? COORD_BITS : ARC_W) + 2;

    logic [mcr_pkg::ORIGIN_W-1:0] origin_x_reg, origin_y_reg;

    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic signed [ARC_W-1:0]      ax_reg, ay_reg;
    logic                         done_reg;
    logic                         busy_reg, busy_next;
    logic [REFL_W-1:0]            refl_reg, refl_next;

    logic                         out_valid_reg;
    logic signed [PIXEL_W-1:0]    pixel_x_reg, pixel_y_reg;
    logic                         last_reg, arc_done_reg;

    logic                         advance, load;
    logic signed [ARC_W-1:0]      dx, dy;
    logic signed [SUM_W-1:0]      sum_x, sum_y;

    assign advance = busy_reg && (!out_valid_reg || out_ready);
    assign load    = job_valid && (!busy_reg || (advance && refl_reg == mcr_pkg::REFL_LAST));
    assign job_pop = load;

    always_comb begin
        busy_next = busy_reg;
        refl_next = refl_reg;
        if (load) begin
            busy_next = 1'b1;
            refl_next = '0;
        end else if (advance) begin
            refl_next = refl_reg + 1'b1;
            if (refl_reg == mcr_pkg::REFL_LAST) begin
                busy_next = 1'b0;
            end
        end
    end

    // reflection order: (x,y) (-x,y) (-x,-y) (x,-y) (y,x) (-y,x) (y,-x) (-y,-x)
    always_comb begin
        case (refl_reg)
            3'd0: begin dx = ax_reg;  dy = ay_reg;  end
            3'd1: begin dx = -ax_reg; dy = ay_reg;  end
            3'd2: begin dx = -ax_reg; dy = -ay_reg; end
            3'd3: begin dx = ax_reg;  dy = -ay_reg; end
            3'd4: begin dx = ay_reg;  dy = ax_reg;  end
            3'd5: begin dx = -ay_reg; dy = ax_reg;  end
            3'd6: begin dx = ay_reg;  dy = -ax_reg; end
            default: begin dx = -ay_reg; dy = -ax_reg; end
        endcase
    end

    assign sum_x = SUM_W'(cx_reg) + SUM_W'(dx) + SUM_W'({1'b0, origin_x_reg});
    assign sum_y = SUM_W'(cy_reg) + SUM_W'(dy) + SUM_W'({1'b0, origin_y_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= mcr_pkg::ORIGIN_RESET;
            origin_y_reg <= mcr_pkg::ORIGIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mcr_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_wdata;
                mcr_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            refl_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            refl_reg <= refl_next;
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cx_reg   <= job_cen_x;
            cy_reg   <= job_cen_y;
            ax_reg   <= job_arc_x;
            ay_reg   <= job_arc_y;
            done_reg <= job_done;
        end
        if (advance) begin
            pixel_x_reg  <= sum_x[PIXEL_W-1:0];
            pixel_y_reg  <= sum_y[PIXEL_W-1:0];
            last_reg     <= (refl_reg == mcr_pkg::REFL_LAST);
            arc_done_reg <= (refl_reg == mcr_pkg::REFL_LAST) && done_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_pixel_x = pixel_x_reg;
    assign out_pixel_y = pixel_y_reg;
    assign out_last    = last_reg;
    assign out_done    = arc_done_reg;

endmodule

>>> rtl/midpoint_circle_rasterizer.sv
// top level of the midpoint circle rasterizer
//
// Slave channel words carry a command in s_tuser: a start latches center and
// radius and gives no output; a step gives eight pixels of the current arc
// point (all eight octant reflections plus center plus screen origin) and
// advances the point. A step while no circle is armed gives nothing.
// Master channel words carry one pixel each; m_tlast marks the eighth pixel
// of a step and m_tuser marks the final pixel of the whole circle.
// A step word's first pixel passes through the job queue, the expander's job
// registers and the output register. Throughput: the output register takes
// one pixel per cycle while m_tready is high. The front end walks the arc
// with an incremental decision value, one step per cycle while the queue is
// not full; the queue lets it run up to QUEUE_DEPTH steps ahead of the expander.
// Reset (aresetn low, synchronous) drops any armed circle, empties the queue
// and output register, and sets both origins to 300. Origin registers are
// written through cfg_wr_en/cfg_index/cfg_wdata, by the user only while the
// block is idle, which it does not enforce. When m_tready is low, the output
// word holds, the expander stops, and s_tready falls once the queue is full.
module midpoint_circle_rasterizer #(
    parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = mcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [mcr_pkg::ORIGIN_W-1:0]        cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cen_x, cen_y, radius, zero fill
    input  logic [((2*COORD_BITS+mcr_pkg::RADIUS_W+7)/8)*8-1:0] s_tdata,
    // command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_x, pixel_y, zero fill
    output logic [((2*mcr_pkg::PIXEL_W+7)/8)*8-1:0] m_tdata,
    output logic                                m_tlast,
    // arc_done
    output logic                                m_tuser
);

    localparam int ARC_W    = mcr_pkg::ARC_W;
    localparam int PIXEL_W  = mcr_pkg::PIXEL_W;
    localparam int RADIUS_W = mcr_pkg::RADIUS_W;
    localparam int JOB_W    = 2*COORD_BITS + 2*ARC_W + 1;
    localparam int M_DATA_W = ((2*PIXEL_W + 7)/8)*8;

    mcr_pkg::queue_wr_t           queue_wr;
    logic                         queue_full, queue_not_empty, queue_pop;
    logic [JOB_W-1:0]             push_data, pop_data;

    logic signed [COORD_BITS-1:0] f_cx, f_cy, b_cx, b_cy;
    logic signed [ARC_W-1:0]      f_ax, f_ay, b_ax, b_ay;
    logic                         f_done, b_done;
    logic                         in_accept;

    logic signed [PIXEL_W-1:0]    pixel_x, pixel_y;

    assign s_tready  = !queue_wr.full;
    assign in_accept = s_tvalid && s_tready;

    mcr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .in_cmd       (mcr_pkg::cmd_t'(s_tuser)),
        .in_cen_x     (s_tdata[COORD_BITS-1:0]),
        .in_cen_y     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_radius    (s_tdata[2*COORD_BITS+RADIUS_W-1:2*COORD_BITS]),
        .queue_full   (queue_full),
        .queue_wr     (queue_wr),
        .job_cen_x    (f_cx),
        .job_cen_y    (f_cy),
        .job_arc_x    (f_ax),
        .job_arc_y    (f_ay),
        .job_done     (f_done)
    );

    assign push_data = {f_done, f_ay, f_ax, f_cy, f_cx};

    mcr_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (queue_wr.push),
        .push_data (push_data),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .pop_data  (pop_data)
    );

    assign {b_done, b_ay, b_ax, b_cy, b_cx} = pop_data;

    mcr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (mcr_pkg::cfg_idx_t'(cfg_index)),
        .cfg_wdata    (cfg_wdata),
        .job_valid    (queue_not_empty),
        .job_cen_x    (b_cx),
        .job_cen_y    (b_cy),
        .job_arc_x    (b_ax),
        .job_arc_y    (b_ay),
        .job_done     (b_done),
        .job_pop      (queue_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_pixel_x  (pixel_x),
        .out_pixel_y  (pixel_y),
        .out_last     (m_tlast),
        .out_done     (m_tuser)
    );

    assign m_tdata = {{(M_DATA_W - 2*PIXEL_W){1'b0}}, pixel_y, pixel_x};

endmodule
